// File: design/ctwo_pkg.sv
// Shared types and constants for the CT window/level overlay pixel pipeline.
// No dependencies; every other design file refers to this package by scoped name.
package ctwo_pkg;

    localparam int HU_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = FRAC_W + 1;
    localparam int GREY_W    = FRAC_W + 1;
    localparam int DIV_STAGES = FRAC_W + 1;
    localparam int EDGE_W    = HU_W + 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
    localparam logic [GREY_W-1:0] GREY_ONE = GREY_W'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_HU        = 3'd0,
        REG_WIDTH_HU        = 3'd1,
        REG_MASK_RED        = 3'd2,
        REG_MASK_GREEN      = 3'd3,
        REG_MASK_BLUE       = 3'd4,
        REG_OVERLAY_OPACITY = 3'd5,
        REG_MASK_EN         = 3'd6,
        REG_COMPARE_ENABLE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [HU_W-1:0] hu_value;
        logic                   in_mask;
        logic                   in_other_mask;
        logic                   on_debug_line;
    } pixel_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha_out;
    } pixel_out_t;

    typedef struct packed {
        logic signed [HU_W-1:0] level_hu;
        logic [HU_W-1:0]        width_hu;
        logic [BYTE_W-1:0]      mask_red;
        logic [BYTE_W-1:0]      mask_green;
        logic [BYTE_W-1:0]      mask_blue;
        logic [BYTE_W-1:0]      overlay_opacity;
        logic                   mask_en;
        logic                   compare_enable;
    } cfg_t;

    // Per-pixel side information carried alongside the divider
    typedef struct packed {
        logic              debug;
        logic              sat_lo;
        logic              sat_hi;
        logic [BYTE_W-1:0] col_r;
        logic [BYTE_W-1:0] col_g;
        logic [BYTE_W-1:0] col_b;
        logic [BYTE_W-1:0] alpha;
    } side_t;

endpackage

// File: design/ct_window_overlay_pixel.sv
// Top level of the CT window/level pixel pipeline with mask overlay blend.
// Depends on ctwo_pkg, ctwo_front, ctwo_div and ctwo_blend.
//
//   port group        dir  handshake        payload
//   s_valid/s_ready   in   valid/ready      s_data  (ctwo_pkg::pixel_in_t)
//   m_valid/m_ready   out  valid/ready      m_data  (ctwo_pkg::pixel_out_t)
//   cfg_wr_en         in   write strobe     cfg_addr, cfg_wdata
//
// One pixel enters per clock while s_ready is high; the pipeline is one front stage, 17 divider
// stages (one quotient bit each) and three blend stages including the output register.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
// Each stage advances when it is empty or its successor advances, so bubbles collapse
// and a stall on m_ready holds every full stage without loss.
module ct_window_overlay_pixel (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ctwo_pkg::pixel_in_t                s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ctwo_pkg::pixel_out_t               m_data,
    input  logic                               cfg_wr_en,
    input  logic [ctwo_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ctwo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    ctwo_pkg::cfg_t                  cfg_reg;
    logic [ctwo_pkg::HU_W-1:0]       width_m1;
    logic [ctwo_pkg::NUM_W-1:0]      den;

    logic                            fr_valid, fr_ready;
    logic [ctwo_pkg::NUM_W-1:0]      fr_num;
    ctwo_pkg::side_t                 fr_side;
    logic                            dv_valid, dv_ready;
    logic [ctwo_pkg::GREY_W-1:0]     dv_quot;
    ctwo_pkg::side_t                 dv_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_hu        <= 16'sd40;
            cfg_reg.width_hu        <= 16'd400;
            cfg_reg.mask_red        <= '0;
            cfg_reg.mask_green      <= '0;
            cfg_reg.mask_blue       <= '0;
            cfg_reg.overlay_opacity <= 8'd128;
            cfg_reg.mask_en         <= 1'b0;
            cfg_reg.compare_enable  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (ctwo_pkg::cfg_reg_t'(cfg_addr))
                ctwo_pkg::REG_LEVEL_HU:        cfg_reg.level_hu        <= cfg_wdata;
                ctwo_pkg::REG_WIDTH_HU:        cfg_reg.width_hu        <= cfg_wdata;
                ctwo_pkg::REG_MASK_RED:        cfg_reg.mask_red        <= cfg_wdata[7:0];
                ctwo_pkg::REG_MASK_GREEN:      cfg_reg.mask_green      <= cfg_wdata[7:0];
                ctwo_pkg::REG_MASK_BLUE:       cfg_reg.mask_blue       <= cfg_wdata[7:0];
                ctwo_pkg::REG_OVERLAY_OPACITY: cfg_reg.overlay_opacity <= cfg_wdata[7:0];
                ctwo_pkg::REG_MASK_EN:         cfg_reg.mask_en         <= cfg_wdata[0];
                ctwo_pkg::REG_COMPARE_ENABLE:  cfg_reg.compare_enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ramp divisor 2*(width-1); unused when the width leaves no ramp
    assign width_m1 = cfg_reg.width_hu - ctwo_pkg::HU_W'(1);
    assign den      = {width_m1, 1'b0};

    ctwo_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_num   (fr_num),
        .out_side  (fr_side)
    );

    ctwo_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .den       (den),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_num    (fr_num),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    ctwo_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_quot   (dv_quot),
        .in_side   (dv_side),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: design/ctwo_front.sv
// Front stage: window edge compares, ramp numerator and overlay color select.
// Depends on ctwo_pkg.
module ctwo_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctwo_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ctwo_pkg::pixel_in_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctwo_pkg::NUM_W-1:0]    out_num,
    output ctwo_pkg::side_t               out_side
);

    logic signed [ctwo_pkg::EDGE_W-1:0] p2, c2, wz, lo_edge, hi_edge, num_s;
    logic                               dm, cmp, im, io;
    ctwo_pkg::side_t                    side_next;
    logic [ctwo_pkg::NUM_W-1:0]         num_next;
    logic                               vld_reg, en;
    logic [ctwo_pkg::NUM_W-1:0]         num_reg;
    ctwo_pkg::side_t                    side_reg;

    always_comb begin
        p2      = {{3{in_data.hu_value[ctwo_pkg::HU_W-1]}}, in_data.hu_value, 1'b0};
        c2      = {{3{cfg.level_hu[ctwo_pkg::HU_W-1]}}, cfg.level_hu, 1'b0};
        wz      = {4'b0, cfg.width_hu};
        lo_edge = c2 - wz;
        hi_edge = c2 + wz - ctwo_pkg::EDGE_W'(2);
        num_s   = p2 - c2 + wz;
        num_next = num_s[ctwo_pkg::NUM_W-1:0];

        dm  = cfg.mask_en;
        cmp = cfg.compare_enable;
        im  = dm & in_data.in_mask;
        io  = cmp & in_data.in_other_mask;

        side_next        = '0;
        side_next.debug  = in_data.on_debug_line;
        side_next.sat_lo = (p2 <= lo_edge);
        side_next.sat_hi = (p2 > hi_edge);

        if (dm && !cmp) begin
            if (im) begin
                side_next.col_r = cfg.mask_red;
                side_next.col_g = cfg.mask_green;
                side_next.col_b = cfg.mask_blue;
                side_next.alpha = cfg.overlay_opacity;
            end
        end else if (!dm && cmp) begin
            if (io) begin
                side_next.col_r = ctwo_pkg::BYTE_MAX;
                side_next.alpha = cfg.overlay_opacity;
            end
        end else if (dm && cmp) begin
            if (io && !im) begin
                side_next.col_r = ctwo_pkg::BYTE_MAX;
                side_next.alpha = cfg.overlay_opacity;
            end else if (io && im) begin
                side_next.col_g = ctwo_pkg::BYTE_MAX;
                side_next.alpha = cfg.overlay_opacity;
            end else if (im) begin
                side_next.col_b = ctwo_pkg::BYTE_MAX;
                side_next.alpha = cfg.overlay_opacity;
            end
        end
    end

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            num_reg  <= num_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_num   = num_reg;
    assign out_side  = side_reg;

endmodule

// File: design/ctwo_div.sv
// Pipelined restoring divider: one quotient bit per stage, num * 2^16 / den.
// Depends on ctwo_pkg; the user must keep the divisor static, as the block does not enforce it.
module ctwo_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ctwo_pkg::NUM_W-1:0]     den,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctwo_pkg::NUM_W-1:0]     in_num,
    input  ctwo_pkg::side_t                in_side,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ctwo_pkg::GREY_W-1:0]    out_quot,
    output ctwo_pkg::side_t                out_side
);

    localparam int LAST = ctwo_pkg::DIV_STAGES - 1;

    logic [ctwo_pkg::DIV_STAGES-1:0] vld_reg;
    logic [ctwo_pkg::DIV_STAGES-1:0] en;
    logic [ctwo_pkg::NUM_W-1:0]      rem_reg  [ctwo_pkg::DIV_STAGES];
    logic [ctwo_pkg::GREY_W-1:0]     quot_reg [ctwo_pkg::DIV_STAGES];
    ctwo_pkg::side_t                 side_reg [ctwo_pkg::DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < ctwo_pkg::DIV_STAGES; j++) begin : g_stage
            logic                          src_valid;
            logic [ctwo_pkg::NUM_W:0]      trial;
            logic [ctwo_pkg::NUM_W:0]      diff;
            logic                          ge;
            logic [ctwo_pkg::GREY_W-1:0]   quot_in;
            ctwo_pkg::side_t               side_in;
            logic [ctwo_pkg::NUM_W-1:0]    rem_next;
            logic [ctwo_pkg::GREY_W-1:0]   quot_next;

            if (j == 0) begin : g_first
                // first stage decides the integer bit without a shift
                assign src_valid = in_valid;
                assign trial     = {1'b0, in_num};
                assign quot_in   = '0;
                assign side_in   = in_side;
            end else begin : g_rest
                assign src_valid = vld_reg[j-1];
                assign trial     = {rem_reg[j-1], 1'b0};
                assign quot_in   = quot_reg[j-1];
                assign side_in   = side_reg[j-1];
            end

            if (j == LAST) begin : g_tail
                assign en[j] = !vld_reg[j] || out_ready;
            end else begin : g_mid
                assign en[j] = !vld_reg[j] || en[j+1];
            end

            assign diff      = trial - {1'b0, den};
            assign ge        = (trial >= {1'b0, den});
            assign rem_next  = ge ? diff[ctwo_pkg::NUM_W-1:0] : trial[ctwo_pkg::NUM_W-1:0];
            assign quot_next = {quot_in[ctwo_pkg::GREY_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[j] <= 1'b0;
                end else if (en[j]) begin
                    vld_reg[j] <= src_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[j] && src_valid) begin
                    rem_reg[j]  <= rem_next;
                    quot_reg[j] <= quot_next;
                    side_reg[j] <= side_in;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];
    assign out_quot  = quot_reg[LAST];
    assign out_side  = side_reg[LAST];

endmodule

// File: design/ctwo_blend.sv
// Three-stage alpha blend of the grey level with the overlay color; the last stage is the
// output register. Depends on ctwo_pkg.
module ctwo_blend (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctwo_pkg::GREY_W-1:0]   in_quot,
    input  ctwo_pkg::side_t               in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ctwo_pkg::pixel_out_t          out_data
);

    localparam int P1_W = ctwo_pkg::GREY_W + ctwo_pkg::BYTE_W;
    localparam int P2_W = 2 * ctwo_pkg::BYTE_W;
    localparam int N_W  = P1_W + ctwo_pkg::BYTE_W;
    localparam int M_W  = 16;

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          en1, en2, en3;

    // stage 1: products
    logic [ctwo_pkg::GREY_W-1:0]   grey;
    logic [ctwo_pkg::BYTE_W-1:0]   inv_a;
    logic [P1_W-1:0]               p1_reg;
    logic [P2_W-1:0]               p2r_reg, p2g_reg, p2b_reg;
    logic                          dbg1_reg;

    // stage 2: scaled sums
    logic [N_W-1:0]                nr, ng, nb;
    logic [M_W-1:0]                mr_reg, mg_reg, mb_reg;
    logic                          dbg2_reg;

    // stage 3: divide by 255
    logic [M_W:0]                  qr, qg, qb;
    ctwo_pkg::pixel_out_t          px_next, px_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        if (in_side.sat_lo) begin
            grey = '0;
        end else if (in_side.sat_hi) begin
            grey = ctwo_pkg::GREY_ONE;
        end else begin
            grey = in_quot;
        end
        inv_a = ctwo_pkg::BYTE_MAX - in_side.alpha;
    end

    // x*255 = (x << 8) - x; overlay term sits at 2^16
    always_comb begin
        nr = ({p1_reg, 8'b0} - N_W'(p1_reg)) + {p2r_reg, 16'b0};
        ng = ({p1_reg, 8'b0} - N_W'(p1_reg)) + {p2g_reg, 16'b0};
        nb = ({p1_reg, 8'b0} - N_W'(p1_reg)) + {p2b_reg, 16'b0};
    end

    // floor(m / 255) for m up to 255*255
    always_comb begin
        qr = {1'b0, mr_reg} + (M_W+1)'(1) + (M_W+1)'(mr_reg[M_W-1:8]);
        qg = {1'b0, mg_reg} + (M_W+1)'(1) + (M_W+1)'(mg_reg[M_W-1:8]);
        qb = {1'b0, mb_reg} + (M_W+1)'(1) + (M_W+1)'(mb_reg[M_W-1:8]);
        px_next.alpha_out = ctwo_pkg::BYTE_MAX;
        if (dbg2_reg) begin
            px_next.red   = ctwo_pkg::BYTE_MAX;
            px_next.green = ctwo_pkg::BYTE_MAX;
            px_next.blue  = ctwo_pkg::BYTE_MAX;
        end else begin
            px_next.red   = qr[15:8];
            px_next.green = qg[15:8];
            px_next.blue  = qb[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            p1_reg   <= grey * inv_a;
            p2r_reg  <= in_side.col_r * in_side.alpha;
            p2g_reg  <= in_side.col_g * in_side.alpha;
            p2b_reg  <= in_side.col_b * in_side.alpha;
            dbg1_reg <= in_side.debug;
        end
        if (en2 && v1_reg) begin
            mr_reg   <= nr[31:16];
            mg_reg   <= ng[31:16];
            mb_reg   <= nb[31:16];
            dbg2_reg <= dbg1_reg;
        end
        if (en3 && v2_reg) begin
            px_reg <= px_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = px_reg;

endmodule

// File: tb/sv/ct_window_overlay_pixel_chk.sv
// Scoreboard for the CT window/level overlay pixel pipeline: predicts each pixel and compares.
// Watches both streams and the register write port; depends on ctwo_pkg.
module ct_window_overlay_pixel_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ctwo_pkg::pixel_in_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ctwo_pkg::pixel_out_t            m_data,
    input  logic                            cfg_wr_en,
    input  logic [ctwo_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ctwo_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending,
    output int                              pixels_checked
);

    localparam int     REPORT_MAX = 10;
    localparam longint UNITY      = 65536;

    ctwo_pkg::cfg_t       regs;
    ctwo_pkg::pixel_out_t expected_pixels[$];
    ctwo_pkg::pixel_out_t want;
    int                   mismatches = 0;
    int                   checked = 0;

    // Grey level as a 1.16 fraction, 1.0 = UNITY
    function automatic longint grey_level(logic signed [ctwo_pkg::HU_W-1:0] hu,
                                          ctwo_pkg::cfg_t c);
        longint p, ctr, w, num, den;
        p   = hu;
        ctr = longint'($signed(c.level_hu));
        w   = c.width_hu;
        if (2 * p <= 2 * ctr - w) return 0;
        if (2 * p > 2 * ctr + w - 2) return UNITY;
        num = 2 * (p - ctr) + w;
        den = 2 * (w - 1);
        if (den <= 0 || num <= 0) return 0;
        return (num * UNITY) / den;
    endfunction

    function automatic logic [ctwo_pkg::BYTE_W-1:0] blend_channel(longint g, longint col,
                                                                  longint a);
        longint v;
        v = (g * (255 - a) * 255 + col * a * UNITY) / (255 * UNITY);
        if (v > 255) v = 255;
        return v[ctwo_pkg::BYTE_W-1:0];
    endfunction

    function automatic ctwo_pkg::pixel_out_t shade_pixel(ctwo_pkg::pixel_in_t px,
                                                         ctwo_pkg::cfg_t c);
        ctwo_pkg::pixel_out_t res;
        longint               g, a, cr, cg, cb;
        logic                 use_m, use_o;
        res.alpha_out = ctwo_pkg::BYTE_MAX;
        if (px.on_debug_line) begin
            res.red   = ctwo_pkg::BYTE_MAX;
            res.green = ctwo_pkg::BYTE_MAX;
            res.blue  = ctwo_pkg::BYTE_MAX;
            return res;
        end
        use_m = c.mask_en && px.in_mask;
        use_o = c.compare_enable && px.in_other_mask;
        cr = 0;
        cg = 0;
        cb = 0;
        a  = 0;
        if (c.mask_en && !c.compare_enable) begin
            if (use_m) begin
                cr = c.mask_red;
                cg = c.mask_green;
                cb = c.mask_blue;
                a  = c.overlay_opacity;
            end
        end else if (!c.mask_en && c.compare_enable) begin
            if (use_o) begin
                cr = 255;
                a  = c.overlay_opacity;
            end
        end else if (c.mask_en && c.compare_enable) begin
            // other only: red, both: green, mask only: blue
            if (use_o && !use_m) begin
                cr = 255;
                a  = c.overlay_opacity;
            end else if (use_o && use_m) begin
                cg = 255;
                a  = c.overlay_opacity;
            end else if (use_m) begin
                cb = 255;
                a  = c.overlay_opacity;
            end
        end
        g = grey_level(px.hu_value, c);
        res.red   = blend_channel(g, cr, a);
        res.green = blend_channel(g, cg, a);
        res.blue  = blend_channel(g, cb, a);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.level_hu        = 16'sd40;
            regs.width_hu        = 16'd400;
            regs.mask_red        = '0;
            regs.mask_green      = '0;
            regs.mask_blue       = '0;
            regs.overlay_opacity = 8'd128;
            regs.mask_en         = 1'b0;
            regs.compare_enable  = 1'b0;
            expected_pixels.delete();
        end else begin
            // a transfer at this edge still sees the settings from before any write here
            if (s_valid && s_ready)
                expected_pixels.push_back(shade_pixel(s_data, regs));
            if (cfg_wr_en) begin
                case (ctwo_pkg::cfg_reg_t'(cfg_addr))
                    ctwo_pkg::REG_LEVEL_HU:        regs.level_hu = cfg_wdata;
                    ctwo_pkg::REG_WIDTH_HU:        regs.width_hu = cfg_wdata;
                    ctwo_pkg::REG_MASK_RED:
                        regs.mask_red = cfg_wdata[ctwo_pkg::BYTE_W-1:0];
                    ctwo_pkg::REG_MASK_GREEN:
                        regs.mask_green = cfg_wdata[ctwo_pkg::BYTE_W-1:0];
                    ctwo_pkg::REG_MASK_BLUE:
                        regs.mask_blue = cfg_wdata[ctwo_pkg::BYTE_W-1:0];
                    ctwo_pkg::REG_OVERLAY_OPACITY:
                        regs.overlay_opacity = cfg_wdata[ctwo_pkg::BYTE_W-1:0];
                    ctwo_pkg::REG_MASK_EN:         regs.mask_en = cfg_wdata[0];
                    ctwo_pkg::REG_COMPARE_ENABLE:  regs.compare_enable = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $time,
                                 m_data.red, m_data.green, m_data.blue, m_data.alpha_out);
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (m_data.red !== want.red || m_data.green !== want.green ||
                        m_data.blue !== want.blue || m_data.alpha_out !== want.alpha_out) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: pixel %0d exp rgba %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $time, checked, want.red, want.green, want.blue,
                                     want.alpha_out, m_data.red, m_data.green, m_data.blue,
                                     m_data.alpha_out);
                    end
                end
            end
        end
        pending        <= expected_pixels.size();
        fail_count     <= mismatches;
        pixels_checked <= checked;
    end

endmodule

// File: tb/sv/ct_window_overlay_pixel_tb.sv
// Top of the CT window/level overlay pixel bench: clock, reset, stimulus, stalls, verdict.
// Depends on ctwo_pkg, ct_window_overlay_pixel and ct_window_overlay_pixel_chk.
module ct_window_overlay_pixel_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 160;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PIXELS   = 150;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ctwo_pkg::pixel_in_t             s_data;
    logic                            m_valid;
    logic                            m_ready;
    ctwo_pkg::pixel_out_t            m_data;
    logic                            cfg_wr_en;
    logic [ctwo_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [ctwo_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int pixels_checked;
    int idle_cycles = 0;
    int settings_used = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stall_on = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ct_window_overlay_pixel u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ct_window_overlay_pixel_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(20, 48);
    endfunction

    function automatic logic [ctwo_pkg::BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 255);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return ctwo_pkg::BYTE_MAX;
            default: return r[ctwo_pkg::BYTE_W-1:0];
        endcase
    endfunction

    function automatic bit pick_bit();
        int r;
        r = $urandom_range(0, 1);
        return r[0];
    endfunction

    function automatic ctwo_pkg::pixel_in_t mk_pixel(int hu, bit m, bit o, bit d);
        ctwo_pkg::pixel_in_t px;
        px.hu_value      = hu[ctwo_pkg::HU_W-1:0];
        px.in_mask       = m;
        px.in_other_mask = o;
        px.on_debug_line = d;
        return px;
    endfunction

    function automatic ctwo_pkg::cfg_t mk_cfg(int center, int width, int r, int g, int b,
                                              int op, bit show, bit cmp);
        ctwo_pkg::cfg_t c;
        c.level_hu        = center[ctwo_pkg::HU_W-1:0];
        c.width_hu        = width[ctwo_pkg::HU_W-1:0];
        c.mask_red        = r[ctwo_pkg::BYTE_W-1:0];
        c.mask_green      = g[ctwo_pkg::BYTE_W-1:0];
        c.mask_blue       = b[ctwo_pkg::BYTE_W-1:0];
        c.overlay_opacity = op[ctwo_pkg::BYTE_W-1:0];
        c.mask_en         = show;
        c.compare_enable  = cmp;
        return c;
    endfunction

    function automatic ctwo_pkg::cfg_t rand_config();
        ctwo_pkg::cfg_t c;
        int             center, width;
        case ($urandom_range(0, 3))
            0: center = int'($urandom_range(0, 400)) - 200;
            1: center = int'($urandom_range(0, 65535)) - 32768;
            2: center = $urandom_range(0, 1) ? 32767 : -32768;
            default: center = int'($urandom_range(0, 4000)) - 2000;
        endcase
        case ($urandom_range(0, 4))
            0: width = 2;
            1: width = 65535;
            2: width = $urandom_range(2, 64);
            3: width = $urandom_range(2, 4000);
            default: width = $urandom_range(2, 65535);
        endcase
        c = mk_cfg(center, width, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                   pick_bit(), pick_bit());
        return c;
    endfunction

    // Aim most pixels at the ramp and its edges, the rest anywhere in range
    function automatic ctwo_pkg::pixel_in_t rand_pixel(ctwo_pkg::cfg_t c);
        int ctr, w, hu, lo_edge, hi_edge;
        ctr = int'($signed(c.level_hu));
        w   = c.width_hu;
        lo_edge = (2 * ctr - w) >>> 1;
        hi_edge = (2 * ctr + w - 2) >>> 1;
        case ($urandom_range(0, 9))
            0, 1, 2: hu = int'($urandom_range(0, 65535)) - 32768;
            3: begin
                case ($urandom_range(0, 3))
                    0: hu = lo_edge;
                    1: hu = lo_edge + 1;
                    2: hu = hi_edge;
                    default: hu = hi_edge + 1;
                endcase
            end
            default: hu = ctr + int'($urandom_range(0, w + 8)) - (w / 2 + 4);
        endcase
        if (hu < -32768) hu = -32768;
        if (hu > 32767) hu = 32767;
        return mk_pixel(hu, pick_bit(), pick_bit(), $urandom_range(0, 9) == 0);
    endfunction

    task automatic send_pixel(ctwo_pkg::pixel_in_t px);
        int gap;
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted pixel has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic put_reg(ctwo_pkg::cfg_reg_t r, logic [ctwo_pkg::CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic load_config(ctwo_pkg::cfg_t c);
        put_reg(ctwo_pkg::REG_LEVEL_HU, c.level_hu);
        put_reg(ctwo_pkg::REG_WIDTH_HU, c.width_hu);
        put_reg(ctwo_pkg::REG_MASK_RED, ctwo_pkg::CFG_DATA_W'(c.mask_red));
        put_reg(ctwo_pkg::REG_MASK_GREEN, ctwo_pkg::CFG_DATA_W'(c.mask_green));
        put_reg(ctwo_pkg::REG_MASK_BLUE, ctwo_pkg::CFG_DATA_W'(c.mask_blue));
        put_reg(ctwo_pkg::REG_OVERLAY_OPACITY, ctwo_pkg::CFG_DATA_W'(c.overlay_opacity));
        put_reg(ctwo_pkg::REG_MASK_EN, ctwo_pkg::CFG_DATA_W'(c.mask_en));
        put_reg(ctwo_pkg::REG_COMPARE_ENABLE, ctwo_pkg::CFG_DATA_W'(c.compare_enable));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Result side: ready runs and stalls, plus one long hold-off on request
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                run = $urandom_range(1, 10);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                stall = rx_stall_on ? pick_gap() : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        ctwo_pkg::cfg_t cfg;
        int             ph;
        int             i;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: window edges at -160 and 240, mask bits ignored
        settings_used = 1;
        send_pixel(mk_pixel(-32768, 1, 1, 0));
        send_pixel(mk_pixel(32767, 0, 0, 0));
        send_pixel(mk_pixel(-160, 0, 1, 0));
        send_pixel(mk_pixel(-159, 1, 0, 0));
        send_pixel(mk_pixel(239, 0, 0, 0));
        send_pixel(mk_pixel(240, 1, 1, 1));

        // Both overlays on, opaque: every mask combination and a debug pixel
        drain();
        load_config(mk_cfg(-100, 1000, 12, 200, 77, 255, 1'b1, 1'b1));
        send_pixel(mk_pixel(0, 0, 0, 0));
        send_pixel(mk_pixel(0, 1, 0, 0));
        send_pixel(mk_pixel(0, 0, 1, 0));
        send_pixel(mk_pixel(0, 1, 1, 0));
        send_pixel(mk_pixel(0, 1, 1, 1));

        // Primary mask only: second mask bit must be ignored
        drain();
        load_config(mk_cfg(20, 300, 255, 128, 3, 200, 1'b1, 1'b0));
        send_pixel(mk_pixel(50, 1, 1, 0));
        send_pixel(mk_pixel(50, 0, 1, 0));

        // Comparison only: primary mask bit must be ignored
        drain();
        load_config(mk_cfg(-20, 333, 9, 9, 9, 77, 1'b0, 1'b1));
        send_pixel(mk_pixel(-50, 1, 1, 0));
        send_pixel(mk_pixel(-50, 1, 0, 0));

        // Widest window at the lowest center, overlay transparent
        drain();
        load_config(mk_cfg(-32768, 65535, 255, 255, 255, 0, 1'b1, 1'b1));
        send_pixel(mk_pixel(-32768, 1, 1, 0));
        send_pixel(mk_pixel(32767, 0, 0, 0));
        send_pixel(mk_pixel(0, 1, 0, 0));

        // Narrowest window at the highest center
        drain();
        load_config(mk_cfg(32767, 2, 0, 0, 0, 255, 1'b0, 1'b0));
        send_pixel(mk_pixel(32766, 0, 0, 0));
        send_pixel(mk_pixel(32767, 1, 1, 0));
        send_pixel(mk_pixel(-32768, 0, 1, 0));

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            cfg = rand_config();
            cfg.mask_en        = ph[0];
            cfg.compare_enable = ph[1];
            if (ph == 0) begin
                cfg.level_hu        = 16'sh8000;
                cfg.width_hu        = 16'd2;
                cfg.overlay_opacity = '0;
            end else if (ph == 1) begin
                cfg.level_hu        = 16'sd32767;
                cfg.width_hu        = 16'hFFFF;
                cfg.overlay_opacity = ctwo_pkg::BYTE_MAX;
            end
            drain();
            load_config(cfg);
            tx_gaps_on  = (ph % 3 != 2);
            rx_stall_on = (ph % 4 != 3);
            // Hold off the result side while offering back to back, to fill the pipe
            if (ph == 5) begin
                tx_gaps_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (i = 0; i < PHASE_PIXELS; i++)
                send_pixel(rand_pixel(cfg));
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("summary: %0d pixels checked over %0d register settings", pixels_checked,
                 settings_used);
        $display("summary: window edges, all overlay modes, debug lines, stalls and back-pressure");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
design/ctwo_pkg.sv
design/ctwo_front.sv
design/ctwo_div.sv
design/ctwo_blend.sv
design/ct_window_overlay_pixel.sv
tb/sv/ct_window_overlay_pixel_chk.sv
tb/sv/ct_window_overlay_pixel_tb.sv
